### hw/rtl/fpff_pkg.sv
// fpff_pkg: shared widths, opcode and status codes and the command struct
// for the fixed-partition first-fit allocator
// no dependencies
`default_nettype none
package fpff_pkg;

  localparam int NUM_PARTS_DEF = 4;
  localparam int NUM_REGS      = 4;

  localparam int OP_W     = 1;
  localparam int ID_W     = 16;
  localparam int SIZE_W   = 10;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 12;
  localparam int PIDX_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOC    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic exec;
  } dp_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/fpff_if.sv
// fpff interfaces: request, result and configuration write channels
// depends on fpff_pkg
`default_nettype none
interface fpff_req_if;
  logic                          valid;
  logic                          ready;
  logic [fpff_pkg::OP_W-1:0]     opcode;
  logic [fpff_pkg::ID_W-1:0]     proc_id;
  logic [fpff_pkg::SIZE_W-1:0]   proc_size;
  modport source (output valid, opcode, proc_id, proc_size, input ready);
  modport sink   (input valid, opcode, proc_id, proc_size, output ready);
endinterface

interface fpff_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fpff_pkg::STATUS_W-1:0] status;
  logic [fpff_pkg::ADDR_W-1:0]   start_addr;
  logic [fpff_pkg::PIDX_W-1:0]   part_index;
  logic [fpff_pkg::SIZE_W-1:0]   leftover;
  modport source (output valid, status, start_addr, part_index, leftover, input ready);
  modport sink   (input valid, status, start_addr, part_index, leftover, output ready);
endinterface

interface fpff_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fpff_pkg::CFG_IDX_W-1:0] index;
  logic [fpff_pkg::SIZE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/fpff_ctrl.sv
// fpff_ctrl: request sequencing and result valid for the allocator
// depends on fpff_pkg
`default_nettype none
module fpff_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fpff_pkg::dp_cmd_t      cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state, state_next;
  logic out_valid_next;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd.load_req   = 1'b0;
    cmd.exec       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait for the result register to drain before committing
        if (out_free) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fpff_dp.sv
// fpff_dp: size registers, partition table, first-fit and owner search,
// result register; depends on fpff_pkg
`default_nettype none
module fpff_dp #(
  parameter int NUM_PARTS = fpff_pkg::NUM_PARTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire fpff_pkg::dp_cmd_t              cmd,
  input  wire logic [fpff_pkg::OP_W-1:0]      opcode,
  input  wire logic [fpff_pkg::ID_W-1:0]      proc_id,
  input  wire logic [fpff_pkg::SIZE_W-1:0]    proc_size,
  input  wire logic                           cfg_we,
  input  wire logic [fpff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fpff_pkg::SIZE_W-1:0]    cfg_data,
  output logic [fpff_pkg::STATUS_W-1:0]       status,
  output logic [fpff_pkg::ADDR_W-1:0]         start_addr,
  output logic [fpff_pkg::PIDX_W-1:0]         part_index,
  output logic [fpff_pkg::SIZE_W-1:0]         leftover
);

  localparam int IDX_W = $clog2(NUM_PARTS);

  logic [fpff_pkg::SIZE_W-1:0] part_size [NUM_PARTS];
  logic [NUM_PARTS-1:0]        part_used;
  logic [fpff_pkg::ID_W-1:0]   owner_id  [NUM_PARTS];

  logic [fpff_pkg::OP_W-1:0]   r_op;
  logic [fpff_pkg::ID_W-1:0]   r_id;
  logic [fpff_pkg::SIZE_W-1:0] r_size;

  logic                        fit_hit;
  logic [IDX_W-1:0]            fit_idx;
  logic [fpff_pkg::ADDR_W-1:0] fit_addr;
  logic [fpff_pkg::SIZE_W-1:0] fit_left;
  logic [fpff_pkg::ADDR_W-1:0] addr_acc;
  logic                        free_hit;
  logic [IDX_W-1:0]            free_idx;

  // partitions past the register list stay at size zero
  for (genvar g = 0; g < NUM_PARTS; g++) begin : g_size
    if (g < fpff_pkg::NUM_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          part_size[g] <= '0;
        end else if (cfg_we && cfg_index == fpff_pkg::CFG_IDX_W'(g)) begin
          part_size[g] <= cfg_data;
        end
      end
    end else begin : g_zero
      assign part_size[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      r_op   <= opcode;
      r_id   <= proc_id;
      r_size <= proc_size;
    end
  end

  // lowest free partition that fits, base address as a running sum, and lowest used partition owned by the id
  always_comb begin
    fit_hit  = 1'b0;
    fit_idx  = '0;
    fit_addr = '0;
    fit_left = '0;
    addr_acc = '0;
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = 0; i < NUM_PARTS; i++) begin
      if (!fit_hit && !part_used[i] && r_size <= part_size[i]) begin
        fit_hit  = 1'b1;
        fit_idx  = IDX_W'(i);
        fit_addr = addr_acc;
        fit_left = part_size[i] - r_size;
      end
      addr_acc = addr_acc + fpff_pkg::ADDR_W'(part_size[i]);
      if (!free_hit && part_used[i] && owner_id[i] == r_id) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_used <= '0;
    end else if (cmd.exec) begin
      if (r_op == fpff_pkg::OP_ALLOC) begin
        if (fit_hit) part_used[fit_idx] <= 1'b1;
      end else if (free_hit) begin
        part_used[free_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && r_op == fpff_pkg::OP_ALLOC && fit_hit) begin
      owner_id[fit_idx] <= r_id;
    end
  end

  // leftover is reckoned from the partition size (less the request size on an allocate), so no leftover table is kept
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status     <= fpff_pkg::ST_NOFIT;
      start_addr <= '0;
      part_index <= '0;
      leftover   <= '0;
      if (r_op == fpff_pkg::OP_ALLOC) begin
        if (fit_hit) begin
          status     <= fpff_pkg::ST_ALLOC;
          start_addr <= fit_addr;
          part_index <= fpff_pkg::PIDX_W'(fit_idx);
          leftover   <= fit_left;
        end
      end else if (free_hit) begin
        status     <= fpff_pkg::ST_FREED;
        part_index <= fpff_pkg::PIDX_W'(free_idx);
        leftover   <= part_size[free_idx];
      end else begin
        status     <= fpff_pkg::ST_NOTFOUND;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fixed_partition_first_fit_allocator.sv
// fixed_partition_first_fit_allocator: top level, joins controller and datapath
// depends on fpff_pkg, fpff_if, fpff_ctrl, fpff_dp
//
// Usage:
//   cfg  - write channel; index 0..3 selects part0_size..part3_size, always
//          ready. Write only while no request is in flight.
//   req  - allocate (opcode 0, proc_id, proc_size) or free (opcode 1, proc_id)
//   rsp  - one result per request: status, start_addr, part_index, leftover
// Order: the request is registered first, and the parallel first-fit / owner
//   search and table update commit once the result register is free, loading
//   the result onto rsp; only one request is in flight.
// Stall: while a result waits on rsp, the next request is accepted and
//   held; it commits as soon as the result register is taken.
// Reset: rst (synchronous) clears sizes to zero, marks every partition free
//   and drops rsp.valid. No clearing pass is needed.
`default_nettype none
module fixed_partition_first_fit_allocator #(
  parameter int NUM_PARTS = fpff_pkg::NUM_PARTS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  fpff_req_if.sink   req,
  fpff_rsp_if.source rsp,
  fpff_cfg_if.sink   cfg
);

  fpff_pkg::dp_cmd_t cmd;

  assign cfg.ready = 1'b1;

  fpff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  fpff_dp #(
    .NUM_PARTS (NUM_PARTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .opcode     (req.opcode),
    .proc_id    (req.proc_id),
    .proc_size  (req.proc_size),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .status     (rsp.status),
    .start_addr (rsp.start_addr),
    .part_index (rsp.part_index),
    .leftover   (rsp.leftover)
  );

endmodule
`default_nettype wire

### hw/rtl/fpff_chk.sv
// fpff_chk: port-level checks for the allocator, bound to the top level
// depends on fpff_pkg, fixed_partition_first_fit_allocator
`default_nettype none
module fpff_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [fpff_pkg::STATUS_W-1:0] status,
  input wire logic [fpff_pkg::ADDR_W-1:0]   start_addr,
  input wire logic [fpff_pkg::PIDX_W-1:0]   part_index,
  input wire logic [fpff_pkg::SIZE_W-1:0]   leftover
);

  // stalled result holds its status and start address
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(start_addr))
    else $error("stalled result changed");

  // one request in flight: no request accepted right after another
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another was in flight");

  // failed requests report zeros
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fpff_pkg::ST_NOFIT || status == fpff_pkg::ST_NOTFOUND)
    |-> start_addr == '0 && part_index == '0 && leftover == '0)
    else $error("failed request with nonzero fields");

  // a free never reports an address
  a_free_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == fpff_pkg::ST_FREED |-> start_addr == '0)
    else $error("free result with nonzero start address");

  // a result follows an accepted request that finds no result waiting
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |-> ##2 out_valid)
    else $error("result missing after request");

endmodule

bind fixed_partition_first_fit_allocator fpff_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .status     (rsp.status),
  .start_addr (rsp.start_addr),
  .part_index (rsp.part_index),
  .leftover   (rsp.leftover)
);
`default_nettype wire
